>>> sv/rnm_pkg.sv
// Shared types and constants for the radius nearest-match block.
`default_nettype none

package rnm_pkg;

  localparam int IDX_W = 16;
  localparam int CNT_W = 11;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_SORT   = 1'b1;

  typedef struct packed {
    logic             busy;
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] id;
  } dist_tag_t;

endpackage

`default_nettype wire

>>> sv/radius_nearest_match_core.sv
// Top level of the fixed-radius nearest-match block: control, table state, result.
//
// Input channel (in_*): mode, point and use bit, taken on in_valid && !in_stall.
// Load, clear and no-op items do not stall the input. A load appends a used point
// to the target table at the next original index. A query scans all stored
// targets, one memory read per cycle, then one result transfer appears on out_*.
// No target is read when the table is empty or use_req is clear; the single read
// port of the target memory sets the rate of one target per cycle. in_stall is
// high while a query is in progress. The result sits in an output register: new
// loads are taken while it waits, but a finished query holds the block until
// out_stall drops. cfg_we writes match_radius (index 0) or check_sorted (index
// 1); do so only while idle. Synchronous active-low reset empties the table,
// clears both flags and the control registers; no clearing pass is needed,
// table entries are only read below the fill count.
`default_nettype none

module radius_nearest_match_core
  import rnm_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [COORD_BITS-2:0]         cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [MODE_W-1:0]             in_mode,
  input  wire logic signed [COORD_BITS-1:0]  in_point_x,
  input  wire logic signed [COORD_BITS-1:0]  in_point_y,
  input  wire logic                          in_use_req,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [IDX_W-1:0]                   out_best_index,
  output logic [2*(COORD_BITS-1)-1:0]        out_best_dist2,
  output logic [CNT_W-1:0]                   out_match_count,
  output logic                               out_unsorted_flag,
  output logic                               out_overflow_flag
);

  localparam int CB  = COORD_BITS;
  localparam int RW  = COORD_BITS - 1;
  localparam int R2W = 2 * RW;
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int MW  = 2 * CB + IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [RW-1:0]        radius_r;
  logic                 sort_en_r;
  logic [R2W-1:0]       r2_r;
  logic [CW-1:0]        count_r;
  logic [IDX_W-1:0]     next_idx_r;
  logic                 spent_r;
  logic signed [CB-1:0] prev_y_r;
  logic                 order_err_r;
  logic                 cap_err_r;
  logic signed [CB-1:0] qx_r, qy_r;
  logic [CW-1:0]        scan_k_r, scan_lim_r;
  logic                 rd_valid_r;
  logic                 found_r;
  logic [IDX_W-1:0]     best_id_r;
  logic [R2W-1:0]       best_d2_r;
  logic [CNT_W-1:0]     match_cnt_r;

  logic                 in_xfer;
  logic                 is_load, is_query, is_clear;
  logic                 table_full;
  logic                 wr_en;
  logic                 rd_en;
  logic [MW-1:0]        rd_data;
  logic [R2W-1:0]       r2_w;
  logic                 scan_done;
  logic                 out_free;
  logic                 take_best;
  dist_tag_t            tag;
  logic [R2W-1:0]       d2;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign is_load    = in_xfer && (in_mode == MODE_LOAD);
  assign is_query   = in_xfer && (in_mode == MODE_QUERY);
  assign is_clear   = in_xfer && (in_mode == MODE_CLEAR);
  assign table_full = spent_r || (count_r >= CW'(CAPACITY));
  assign wr_en      = is_load && in_use_req && !table_full;
  assign rd_en      = (state_r == ST_SCAN) && (scan_k_r < scan_lim_r);
  assign scan_done  = (state_r == ST_SCAN) && (scan_k_r == scan_lim_r) &&
                      !rd_valid_r && !tag.busy;
  assign out_free   = !out_valid || !out_stall;
  assign r2_w       = radius_r * radius_r;
  assign take_best  = tag.valid && tag.hit &&
                      (!found_r || (d2 < best_d2_r) ||
                       ((d2 == best_d2_r) && (tag.id < best_id_r)));

  rnm_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (MW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({next_idx_r, in_point_y, in_point_x}),
    .rd_en   (rd_en),
    .rd_addr (scan_k_r[AW-1:0]),
    .rd_data (rd_data)
  );

  rnm_dist #(
    .CB  (CB),
    .R2W (R2W)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_valid_r),
    .tgt_x  (rd_data[CB-1:0]),
    .tgt_y  (rd_data[2*CB-1:CB]),
    .tgt_id (rd_data[MW-1:2*CB]),
    .qx     (qx_r),
    .qy     (qy_r),
    .r2     (r2_r),
    .tag    (tag),
    .d2     (d2)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_query) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    r2_r <= r2_w;
    if (is_query) begin
      qx_r <= in_point_x;
      qy_r <= in_point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= '0;
      sort_en_r   <= 1'b0;
      count_r     <= '0;
      next_idx_r  <= '0;
      spent_r     <= 1'b0;
      prev_y_r    <= {1'b1, {(CB-1){1'b0}}};
      order_err_r <= 1'b0;
      cap_err_r   <= 1'b0;
      scan_k_r    <= '0;
      scan_lim_r  <= '0;
      rd_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      best_id_r   <= '0;
      best_d2_r   <= '0;
      match_cnt_r <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RADIUS: radius_r  <= cfg_wdata;
          CFG_SORT:   sort_en_r <= cfg_wdata[0];
          default:    ;
        endcase
      end

      if (is_load) begin
        next_idx_r <= next_idx_r + IDX_W'(1);
        if (next_idx_r == {IDX_W{1'b1}}) begin
          spent_r <= 1'b1;
        end
        if (in_use_req) begin
          if (sort_en_r) begin
            if (in_point_y < prev_y_r) begin
              order_err_r <= 1'b1;
            end
            prev_y_r <= in_point_y;
          end
          if (table_full) begin
            cap_err_r <= 1'b1;
          end else begin
            count_r <= count_r + CW'(1);
          end
        end
      end

      if (is_clear) begin
        count_r     <= '0;
        next_idx_r  <= '0;
        spent_r     <= 1'b0;
        prev_y_r    <= {1'b1, {(CB-1){1'b0}}};
        order_err_r <= 1'b0;
        cap_err_r   <= 1'b0;
      end

      if (is_query) begin
        scan_k_r    <= '0;
        scan_lim_r  <= in_use_req ? count_r : '0;
        found_r     <= 1'b0;
        best_id_r   <= '0;
        best_d2_r   <= '0;
        match_cnt_r <= '0;
      end

      if (rd_en) begin
        scan_k_r <= scan_k_r + CW'(1);
      end

      if (tag.valid && tag.hit) begin
        match_cnt_r <= match_cnt_r + CNT_W'(1);
      end
      if (take_best) begin
        found_r   <= 1'b1;
        best_id_r <= tag.id;
        best_d2_r <= d2;
      end

      if (((state_r == ST_SCAN && scan_done) || state_r == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (((state_r == ST_SCAN && scan_done) || state_r == ST_DONE) && out_free) begin
      out_found         <= found_r;
      out_best_index    <= best_id_r;
      out_best_dist2    <= best_d2_r;
      out_match_count   <= match_cnt_r;
      out_unsorted_flag <= order_err_r;
      out_overflow_flag <= cap_err_r;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_k_r <= scan_lim_r))
    else $error("scan pointer past limit");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_valid_r && !tag.busy))
    else $error("reads in flight while idle");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_best_index == '0 && out_best_dist2 == '0))
    else $error("no-match result carries nonzero index or distance");

endmodule

`default_nettype wire

>>> sv/rnm_mem.sv
// Target table memory: one write port, one read port, registered read data.
`default_nettype none

module rnm_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/rnm_dist.sv
// Squared-distance pipeline: abs diff, square, sum and radius compare.
`default_nettype none

module rnm_dist
  import rnm_pkg::*;
#(
  parameter int CB  = 24,
  parameter int R2W = 46
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_vld,
  input  wire logic signed [CB-1:0] tgt_x,
  input  wire logic signed [CB-1:0] tgt_y,
  input  wire logic [IDX_W-1:0]     tgt_id,
  input  wire logic signed [CB-1:0] qx,
  input  wire logic signed [CB-1:0] qy,
  input  wire logic [R2W-1:0]       r2,
  output dist_tag_t                 tag,
  output logic [R2W-1:0]            d2
);

  logic signed [CB:0] ex;
  logic signed [CB:0] ey;
  logic [CB-1:0]      dx;
  logic [CB-1:0]      dy;
  logic [2*CB:0]      sum;

  logic               v1_r, v2_r, v3_r;
  logic [CB-1:0]      dx_r, dy_r;
  logic [IDX_W-1:0]   id1_r, id2_r, id3_r;
  logic [2*CB-1:0]    dx2_r, dy2_r;
  logic               hit_r;
  logic [R2W-1:0]     d2_r;

  assign ex  = {tgt_x[CB-1], tgt_x} - {qx[CB-1], qx};
  assign ey  = {tgt_y[CB-1], tgt_y} - {qy[CB-1], qy};
  assign dx  = ex[CB] ? CB'(-ex) : ex[CB-1:0];
  assign dy  = ey[CB] ? CB'(-ey) : ey[CB-1:0];
  assign sum = {1'b0, dx2_r} + {1'b0, dy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx;
    dy_r     <= dy;
    id1_r    <= tgt_id;
    dx2_r    <= dx_r * dx_r;
    dy2_r    <= dy_r * dy_r;
    id2_r    <= id1_r;
    hit_r    <= sum <= {{(2*CB+1-R2W){1'b0}}, r2};
    d2_r     <= sum[R2W-1:0];
    id3_r    <= id2_r;
  end

  assign tag.busy   = v1_r | v2_r | v3_r;
  assign tag.valid  = v3_r;
  assign tag.hit    = hit_r;
  assign tag.id     = id3_r;
  assign d2         = d2_r;

endmodule

`default_nettype wire

>>> tb/sv/radius_nearest_match_core_tb.sv
// Self-checking testbench for radius_nearest_match_core: table loads, queries, flags.
`default_nettype none

module radius_nearest_match_core_tb;
  import rnm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = 24;
  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_FAIL_PRINTS = 10;
  localparam logic [COORD_W-2:0] RADIUS_MAX = '1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                    found;
    logic [IDX_W-1:0]        best_idx;
    logic [2*(COORD_W-1)-1:0] best_d2;
    logic [CNT_W-1:0]        hits;
    logic                    unsorted;
    logic                    overflow;
  } match_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [MODE_W-1:0] mode;
    coord_t            x;
    coord_t            y;
    logic              use_bit;
    bit                typed;
    match_result_t     res;
    logic              cfg_idx;
    logic [COORD_W-2:0] cfg_data;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [COORD_W-2:0]       cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode;
  coord_t                   in_point_x;
  coord_t                   in_point_y;
  logic                     in_use_req;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_found;
  logic [IDX_W-1:0]         out_best_index;
  logic [2*(COORD_W-1)-1:0] out_best_dist2;
  logic [CNT_W-1:0]         out_match_count;
  logic                     out_unsorted_flag;
  logic                     out_overflow_flag;

  radius_nearest_match_core #(
    .CAPACITY   (TABLE_DEPTH),
    .COORD_BITS (COORD_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_use_req        (in_use_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_best_index    (out_best_index),
    .out_best_dist2    (out_best_dist2),
    .out_match_count   (out_match_count),
    .out_unsorted_flag (out_unsorted_flag),
    .out_overflow_flag (out_overflow_flag)
  );

  // Shadow of the target table and the control registers
  coord_t             tbl_x [TABLE_DEPTH];
  coord_t             tbl_y [TABLE_DEPTH];
  logic [IDX_W-1:0]   tbl_id [TABLE_DEPTH];
  int                 tbl_fill;
  logic [IDX_W-1:0]   load_seq;
  bit                 seq_wrapped;
  coord_t             last_y;
  bit                 order_bad;
  bit                 full_bad;
  logic [COORD_W-2:0] radius_q;
  bit                 sort_on;

  match_result_t expected_q [$];
  dir_row_t      dir_rows [$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_cnt;
  int items_sent;
  int queries_sent;
  int results_checked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic note_failure(input string what, input longint unsigned want,
                              input longint unsigned got);
    fail_cnt++;
    if (fail_cnt <= MAX_FAIL_PRINTS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  function automatic coord_t clamp24(input longint v);
    if (v > 64'sd8388607) return coord_t'(24'sd8388607);
    if (v < -64'sd8388608) return coord_t'(-24'sd8388608);
    return coord_t'(v);
  endfunction

  function automatic coord_t near(input longint c, input longint s);
    return clamp24(c + longint'($urandom_range(int'(2 * s))) - s);
  endfunction

  function automatic match_result_t scan_targets(input coord_t px, input coord_t py,
                                                 input logic use_bit);
    match_result_t res;
    longint r2, dx, dy, d2, best;
    int hits;
    res = '0;
    best = 0;
    hits = 0;
    r2 = longint'(radius_q) * longint'(radius_q);
    if (use_bit) begin
      for (int k = 0; k < tbl_fill; k++) begin
        dx = longint'(tbl_x[k]) - longint'(px);
        dy = longint'(tbl_y[k]) - longint'(py);
        d2 = dx * dx + dy * dy;
        if (d2 <= r2) begin
          hits++;
          if (!res.found || d2 < best || (d2 == best && tbl_id[k] < res.best_idx)) begin
            res.found = 1'b1;
            best = d2;
            res.best_idx = tbl_id[k];
          end
        end
      end
    end
    res.best_d2 = best[2*(COORD_W-1)-1:0];
    res.hits = hits[CNT_W-1:0];
    res.unsorted = order_bad;
    res.overflow = full_bad;
    return res;
  endfunction

  task automatic clear_shadow();
    tbl_fill = 0;
    load_seq = '0;
    seq_wrapped = 1'b0;
    last_y = coord_t'(-24'sd8388608);
    order_bad = 1'b0;
    full_bad = 1'b0;
  endtask

  // Advance the shadow state by one accepted transfer
  task automatic table_step(input logic [MODE_W-1:0] mode, input coord_t px, input coord_t py,
                            input logic use_bit, output bit is_query,
                            output match_result_t res);
    logic [IDX_W-1:0] idx;
    bit spent;
    is_query = 1'b0;
    res = '0;
    case (mode)
      MODE_LOAD: begin
        idx = load_seq;
        spent = seq_wrapped;
        load_seq = load_seq + 1'b1;
        if (load_seq == '0) seq_wrapped = 1'b1;
        if (use_bit) begin
          if (sort_on) begin
            if (py < last_y) order_bad = 1'b1;
            last_y = py;
          end
          if (spent || tbl_fill >= TABLE_DEPTH) begin
            full_bad = 1'b1;
          end else begin
            tbl_x[tbl_fill] = px;
            tbl_y[tbl_fill] = py;
            tbl_id[tbl_fill] = idx;
            tbl_fill++;
          end
        end
      end
      MODE_QUERY: begin
        is_query = 1'b1;
        res = scan_targets(px, py, use_bit);
      end
      MODE_CLEAR: clear_shadow();
      default: ;
    endcase
  endtask

  // Called and returns at a falling edge
  task automatic send_item(input logic [MODE_W-1:0] mode, input coord_t px, input coord_t py,
                           input logic use_bit, input bit typed, input match_result_t typed_res);
    bit is_query;
    match_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_point_x <= px;
    in_point_y <= py;
    in_use_req <= use_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_step(mode, px, py, use_bit, is_query, res);
    items_sent++;
    if (is_query) begin
      queries_sent++;
      expected_q.insert(expected_q.size(), typed ? typed_res : res);
    end
    @(negedge clk);
  endtask

  task automatic send(input logic [MODE_W-1:0] mode, input coord_t px, input coord_t py,
                      input logic use_bit);
    send_item(mode, px, py, use_bit, 1'b0, '0);
  endtask

  task automatic cfg_write(input logic idx, input logic [COORD_W-2:0] data);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RADIUS) radius_q = data;
    else sort_on = data[0];
  endtask

  task automatic add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  function automatic dir_row_t row_item(input logic [MODE_W-1:0] mode, input coord_t x,
                                        input coord_t y, input logic use_bit);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.mode = mode;
    r.x = x;
    r.y = y;
    r.use_bit = use_bit;
    r.typed = 1'b0;
    r.res = '0;
    r.cfg_idx = CFG_RADIUS;
    r.cfg_data = '0;
    return r;
  endfunction

  function automatic dir_row_t row_typed(input logic [MODE_W-1:0] mode, input coord_t x,
                                         input coord_t y, input logic use_bit,
                                         input bit f, input int idx, input longint d2,
                                         input int hits, input bit uns, input bit ovf);
    dir_row_t r;
    r = row_item(mode, x, y, use_bit);
    r.typed = 1'b1;
    r.res.found = f;
    r.res.best_idx = idx[IDX_W-1:0];
    r.res.best_d2 = d2[2*(COORD_W-1)-1:0];
    r.res.hits = hits[CNT_W-1:0];
    r.res.unsorted = uns;
    r.res.overflow = ovf;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic idx, input logic [COORD_W-2:0] data);
    dir_row_t r;
    r = row_item(MODE_NOP, '0, '0, 1'b0);
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_data = data;
    return r;
  endfunction

  // Clustered loads with mostly ascending y, then queries around the cluster
  task automatic run_cluster(inout int done);
    longint s, yy;
    coord_t cx, cy, lx, ly, qx, qy;
    int nload, nq;
    if (tbl_fill > 150 || $urandom_range(99) < 30) begin
      send(MODE_CLEAR, coord_t'($urandom), coord_t'($urandom), 1'($urandom));
      done++;
    end
    s = longint'(radius_q) + longint'(radius_q) / 2 + 4;
    cx = coord_t'($urandom);
    cy = coord_t'($urandom);
    yy = longint'(cy) - s;
    lx = cx;
    ly = cy;
    nload = $urandom_range(1, 10);
    for (int i = 0; i < nload; i++) begin
      if ($urandom_range(99) >= 15) begin
        lx = near(cx, s);
        yy = yy + longint'($urandom_range(int'(s / 4 + 1)));
        ly = ($urandom_range(99) < 10) ? near(cy, s) : clamp24(yy);
      end
      send(MODE_LOAD, lx, ly, $urandom_range(99) < 90);
      done++;
    end
    nq = $urandom_range(1, 4);
    for (int i = 0; i < nq; i++) begin
      qx = lx;
      qy = ly;
      if ($urandom_range(99) >= 30) begin
        qx = near(cx, s);
        qy = near(cy, s);
      end
      send(MODE_QUERY, qx, qy, $urandom_range(99) < 90);
      done++;
    end
  endtask

  task automatic run_random(input int n);
    int done;
    logic [MODE_W-1:0] mode;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 20) begin
        mode = MODE_W'($urandom_range(3));
        send(mode, coord_t'($urandom), coord_t'($urandom), 1'($urandom));
        if (mode != MODE_NOP) done++;
      end else begin
        run_cluster(done);
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    match_result_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        note_failure("result transfer with no query pending", 0, 1);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (out_found !== want.found)
          note_failure("found", 64'(want.found), 64'(out_found));
        if (out_best_index !== want.best_idx)
          note_failure("best_index", 64'(want.best_idx), 64'(out_best_index));
        if (out_best_dist2 !== want.best_d2)
          note_failure("best_dist2", 64'(want.best_d2), 64'(out_best_dist2));
        if (out_match_count !== want.hits)
          note_failure("match_count", 64'(want.hits), 64'(out_match_count));
        if (out_unsorted_flag !== want.unsorted)
          note_failure("unsorted_flag", 64'(want.unsorted), 64'(out_unsorted_flag));
        if (out_overflow_flag !== want.overflow)
          note_failure("overflow_flag", 64'(want.overflow), 64'(out_overflow_flag));
      end
    end
  end

  initial begin
    int waited;
    int leftover;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_RADIUS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_NOP;
    in_point_x = '0;
    in_point_y = '0;
    in_use_req = 1'b0;
    fail_cnt = 0;
    items_sent = 0;
    queries_sent = 0;
    results_checked = 0;
    send_idle_pct = 31;
    recv_idle_pct = 71;
    radius_q = '0;
    sort_on = 1'b0;
    clear_shadow();

    add_row(row_cfg(CFG_SORT, 1));
    add_row(row_typed(MODE_QUERY, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(row_cfg(CFG_RADIUS, RADIUS_MAX));
    add_row(row_item(MODE_LOAD, 0, 0, 1));
    add_row(row_typed(MODE_QUERY, 8388607, 0, 1, 1, 0, 64'd70368727400449, 1, 0, 0));
    add_row(row_typed(MODE_QUERY, 8388607, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(row_item(MODE_LOAD, -1, -1, 0));
    add_row(row_item(MODE_LOAD, -8388608, -8388608, 1));
    add_row(row_item(MODE_LOAD, -8388608, 8388607, 1));
    add_row(row_item(MODE_LOAD, 0, 0, 1));
    add_row(row_item(MODE_QUERY, 0, 0, 1));
    add_row(row_item(MODE_QUERY, -8388608, -8388608, 1));
    add_row(row_item(MODE_NOP, 8388607, -8388608, 1));
    add_row(row_item(MODE_QUERY, 8388607, 8388607, 1));
    add_row(row_item(MODE_CLEAR, 0, 0, 0));
    add_row(row_typed(MODE_QUERY, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(row_cfg(CFG_RADIUS, 0));
    add_row(row_cfg(CFG_SORT, 0));
    add_row(row_item(MODE_LOAD, 5, 5, 1));
    add_row(row_item(MODE_QUERY, 5, 5, 1));
    add_row(row_item(MODE_QUERY, 5, 6, 1));
    add_row(row_item(MODE_QUERY, -8388608, 8388607, 0));
    add_row(row_item(MODE_CLEAR, -8388608, 8388607, 1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        cfg_write(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
      else
        send_item(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y, dir_rows[i].use_bit,
                  dir_rows[i].typed, dir_rows[i].res);
    end

    cfg_write(CFG_RADIUS, (COORD_W-1)'($urandom_range(1, 5000)));
    cfg_write(CFG_SORT, 1);
    run_random(150);

    send_idle_pct = 71;
    recv_idle_pct = 31;
    cfg_write(CFG_RADIUS, RADIUS_MAX);
    cfg_write(CFG_SORT, 0);
    run_random(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(CFG_RADIUS, (COORD_W-1)'($urandom_range(0, 8388607)));
    cfg_write(CFG_SORT, 1);
    run_random(150);

    in_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    leftover = expected_q.size();
    if (leftover != 0) note_failure("query results never returned", 0, 64'(leftover));

    $display("%0d transfers in (%0d queries), %0d results checked under three stall mixes;",
             items_sent, queries_sent, results_checked);
    $display("loads, clears, sort checks and radius extremes exercised, %0d failures.",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/rnm_pkg.sv
sv/rnm_mem.sv
sv/rnm_dist.sv
sv/radius_nearest_match_core.sv
tb/sv/radius_nearest_match_core_tb.sv
